FILE: rtl/mm64_pkg.sv
package mm64_pkg;

	// default operand width
	localparam int unsigned OPERAND_BITS_DEF = 63;

endpackage

FILE: rtl/mm64_if.sv
interface mm64_in_if #(
	parameter int unsigned OPERAND_BITS = mm64_pkg::OPERAND_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] factor_a;
	logic [OPERAND_BITS-1:0] factor_b;
	logic [OPERAND_BITS-1:0] modulus;

	modport source (output valid, output factor_a, output factor_b, output modulus,
		input ready);
	modport sink (input valid, input factor_a, input factor_b, input modulus,
		output ready);
endinterface

interface mm64_out_if #(
	parameter int unsigned OPERAND_BITS = mm64_pkg::OPERAND_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] remainder;
	logic                    zero_modulus;

	modport source (output valid, output remainder, output zero_modulus, input ready);
	modport sink (input valid, input remainder, input zero_modulus, output ready);
endinterface

FILE: rtl/modular_multiply_64.sv
// Each item passes from the input transfer through every cell and then the output register to the result.
// Throughput: one item per cycle while the output is not stalled; a chain of 2*OPERAND_BITS cells, one bit per cell,
// first reducing factor_b mod modulus, then folding in factor_a MSB first.
// The whole chain advances together and holds while the output register is stalled.
// Reset (arst_n low, asynchronous) clears all valid flags; the pipeline empties.
module modular_multiply_64 #(
	parameter int unsigned OPERAND_BITS = mm64_pkg::OPERAND_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mm64_in_if.sink    in_ch,
	mm64_out_if.source out_ch
);
	localparam int unsigned N = OPERAND_BITS;

	logic         adv;
	logic         vld_c [0:2*N];
	logic [N-1:0] a_c   [0:2*N];
	logic [N-1:0] b_c   [0:2*N];
	logic [N-1:0] m_c   [0:2*N];
	logic [N-1:0] r_c   [0:2*N];

	// advance whenever the output register is free or being taken
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	assign vld_c[0] = in_ch.valid;
	assign a_c[0]   = in_ch.factor_a;
	assign b_c[0]   = in_ch.factor_b;
	assign m_c[0]   = in_ch.modulus;
	assign r_c[0]   = '0;

	// reduction cells: bits of factor_b, MSB first
	for (genvar i = 0; i < N; i++) begin : g_red
		mm64_red_cell #(.OPERAND_BITS(N), .IDX(N - 1 - i)) u_cell (
			.clk  (clk),
			.arst_n(arst_n),
			.en   (adv),
			.vld_i(vld_c[i]),
			.a_i  (a_c[i]),
			.b_i  (b_c[i]),
			.m_i  (m_c[i]),
			.r_i  (r_c[i]),
			.vld_o(vld_c[i+1]),
			.a_o  (a_c[i+1]),
			.b_o  (b_c[i+1]),
			.m_o  (m_c[i+1]),
			.r_o  (r_c[i+1])
		);
	end

	// multiply cells: bits of factor_a, MSB first; b lane carries b mod m
	for (genvar j = 0; j < N; j++) begin : g_mul
		mm64_mul_cell #(.OPERAND_BITS(N), .IDX(N - 1 - j)) u_cell (
			.clk  (clk),
			.arst_n(arst_n),
			.en   (adv),
			.vld_i(vld_c[N+j]),
			.a_i  (a_c[N+j]),
			.bm_i (j == 0 ? r_c[N] : b_c[N+j]),
			.m_i  (m_c[N+j]),
			.r_i  (j == 0 ? '0 : r_c[N+j]),
			.vld_o(vld_c[N+j+1]),
			.a_o  (a_c[N+j+1]),
			.bm_o (b_c[N+j+1]),
			.m_o  (m_c[N+j+1]),
			.r_o  (r_c[N+j+1])
		);
	end

	// output register: force zero result on a zero modulus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= vld_c[2*N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.zero_modulus <= (m_c[2*N] == '0);
			out_ch.remainder    <= (m_c[2*N] == '0) ? '0 : r_c[2*N];
		end
	end
endmodule

FILE: rtl/mm64_red_cell.sv
// One step of restoring reduction: shift in one bit of factor_b
module mm64_red_cell #(
	parameter int unsigned OPERAND_BITS = mm64_pkg::OPERAND_BITS_DEF,
	parameter int unsigned IDX          = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic [OPERAND_BITS-1:0] a_i,
	input  logic [OPERAND_BITS-1:0] b_i,
	input  logic [OPERAND_BITS-1:0] m_i,
	input  logic [OPERAND_BITS-1:0] r_i,
	output logic                    vld_o,
	output logic [OPERAND_BITS-1:0] a_o,
	output logic [OPERAND_BITS-1:0] b_o,
	output logic [OPERAND_BITS-1:0] m_o,
	output logic [OPERAND_BITS-1:0] r_o
);
	logic [OPERAND_BITS:0] sh;
	logic [OPERAND_BITS:0] nxt;

	// double and add the next bit, subtract once if at or above m
	always_comb begin
		sh = {r_i, b_i[IDX]};
		if (sh >= {1'b0, m_i}) begin
			nxt = sh - {1'b0, m_i};
		end else begin
			nxt = sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			a_o <= a_i;
			b_o <= b_i;
			m_o <= m_i;
			r_o <= nxt[OPERAND_BITS-1:0];
		end
	end
endmodule

FILE: rtl/mm64_mul_cell.sv
// One step of interleaved modular multiplication over one bit of factor_a
module mm64_mul_cell #(
	parameter int unsigned OPERAND_BITS = mm64_pkg::OPERAND_BITS_DEF,
	parameter int unsigned IDX          = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_i,
	input  logic [OPERAND_BITS-1:0] a_i,
	input  logic [OPERAND_BITS-1:0] bm_i,
	input  logic [OPERAND_BITS-1:0] m_i,
	input  logic [OPERAND_BITS-1:0] r_i,
	output logic                    vld_o,
	output logic [OPERAND_BITS-1:0] a_o,
	output logic [OPERAND_BITS-1:0] bm_o,
	output logic [OPERAND_BITS-1:0] m_o,
	output logic [OPERAND_BITS-1:0] r_o
);
	logic [OPERAND_BITS:0] dbl;
	logic [OPERAND_BITS:0] red;
	logic [OPERAND_BITS:0] acc;
	logic [OPERAND_BITS:0] nxt;

	// r = 2r mod m, then add bm when the bit is set and reduce again
	always_comb begin
		dbl = {r_i, 1'b0};
		if (dbl >= {1'b0, m_i}) begin
			red = dbl - {1'b0, m_i};
		end else begin
			red = dbl;
		end
		acc = red + (a_i[IDX] ? {1'b0, bm_i} : '0);
		if (acc >= {1'b0, m_i}) begin
			nxt = acc - {1'b0, m_i};
		end else begin
			nxt = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_o  <= a_i;
			bm_o <= bm_i;
			m_o  <= m_i;
			r_o  <= nxt[OPERAND_BITS-1:0];
		end
	end
endmodule

FILE: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned W         = mm64_pkg::OPERAND_BITS_DEF;
	localparam int unsigned LATENCY   = 2 * W + 1;
	localparam int unsigned IDLE_LIMIT = 20000;

	typedef logic [W-1:0] operand_t;

	typedef struct packed {
		operand_t remainder;
		logic     zero_modulus;
	} mod_result_t;

	logic clk;
	logic arst_n;

	mm64_in_if  #(.OPERAND_BITS(W)) in_ch ();
	mm64_out_if #(.OPERAND_BITS(W)) out_ch ();

	modular_multiply_64 #(.OPERAND_BITS(W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	mod_result_t pending_rem[$];
	int unsigned error_count;
	int unsigned sent_count;
	int unsigned checked_count;
	int unsigned zero_mod_count;
	int unsigned idle_cycles;
	bit          no_idle;

	// Clock and single reset at start of run
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.factor_a  = '0;
		in_ch.factor_b  = '0;
		in_ch.modulus   = '0;
		out_ch.ready    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Exact double-width product reduced by the modulus
	function automatic mod_result_t mod_product(operand_t a, operand_t b, operand_t m);
		logic [2*W-1:0] prod;
		logic [2*W-1:0] wide_m;
		mod_result_t    res;
		if (m == '0) begin
			res.remainder    = '0;
			res.zero_modulus = 1'b1;
		end else begin
			prod             = {{W{1'b0}}, a} * {{W{1'b0}}, b};
			wide_m           = {{W{1'b0}}, m};
			prod             = prod % wide_m;
			res.remainder    = prod[W-1:0];
			res.zero_modulus = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Gap length: mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		else if (roll < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(60, 10);
	endfunction

	// Send one transfer and record its expected result
	task automatic send_item(input operand_t a, input operand_t b, input operand_t m);
		int unsigned gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.factor_a <= a;
		in_ch.factor_b <= b;
		in_ch.modulus  <= m;
		do @(posedge clk); while (!in_ch.ready);
		pending_rem.push_back(mod_product(a, b, m));
		sent_count++;
		if (m == '0)
			zero_mod_count++;
	endtask

	// Sink side: hold ready low for random stalls
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (no_idle) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				out_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		mod_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_rem.size() == 0) begin
				report_mismatch($sformatf("unexpected result rem=%h", out_ch.remainder));
			end else begin
				want = pending_rem.pop_front();
				checked_count++;
				if (out_ch.remainder !== want.remainder)
					report_mismatch($sformatf("remainder got %h want %h",
						out_ch.remainder, want.remainder));
				if (out_ch.zero_modulus !== want.zero_modulus)
					report_mismatch($sformatf("zero_modulus got %b want %b",
						out_ch.zero_modulus, want.zero_modulus));
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic operand_t rand_full();
		return operand_t'({$urandom, $urandom});
	endfunction

	// Operand drawn from a mix of extremes, small values, powers of two and full range
	function automatic operand_t rand_operand();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return operand_t'($urandom_range(255));
			3:       return operand_t'(1) << $urandom_range(W - 1);
			4:       return '1 - operand_t'($urandom_range(15));
			default: return rand_full();
		endcase
	endfunction

	function automatic operand_t rand_modulus();
		case ($urandom_range(19))
			0:       return '0;
			1:       return operand_t'(1);
			2, 3:    return operand_t'($urandom_range(1000, 2));
			4:       return operand_t'(1) << $urandom_range(W - 1);
			5:       return '1;
			default: return rand_full();
		endcase
	endfunction

	task automatic test_directed();
		operand_t top;
		top = '1;
		send_item('0, '0, '0);
		send_item(top, top, '0);
		send_item('0, top, top);
		send_item(top, '0, operand_t'(7));
		send_item(top, top, top);
		send_item(top, top, top - 1);
		send_item(top, top, operand_t'(1));
		send_item(top, top, operand_t'(2));
		send_item(operand_t'(1), operand_t'(1), top);
		send_item(top - 1, top - 1, top);
		send_item(operand_t'(1) << (W - 1), operand_t'(1) << (W - 1), top);
		send_item(operand_t'(12345), operand_t'(67890), operand_t'(97));
		send_item(top, operand_t'(1), operand_t'(1) << (W - 1));
		send_item(operand_t'(3), operand_t'(5), operand_t'(16));
		send_item(rand_full(), rand_full(), rand_full());
		send_item(rand_full(), rand_full(), operand_t'(1) << (W - 1) | operand_t'(1));
	endtask

	// Full-rate stretch with no idling on either side
	task automatic test_back_to_back(input int unsigned count);
		no_idle = 1'b1;
		repeat (count) send_item(rand_operand(), rand_operand(), rand_modulus());
		no_idle = 1'b0;
	endtask

	task automatic test_random_idle(input int unsigned count);
		repeat (count) send_item(rand_operand(), rand_operand(), rand_modulus());
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		wait (pending_rem.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (pending_rem.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_rem.size()));
	endtask

	initial begin
		error_count    = 0;
		sent_count     = 0;
		checked_count  = 0;
		zero_mod_count = 0;
		no_idle        = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_back_to_back(200);
		test_random_idle(550);
		drain_results();
		$display("covered %0d multiplications (%0d with zero modulus), %0d results checked",
			sent_count, zero_mod_count, checked_count);
		$display("mix of extremes, small moduli, powers of two, full-rate and stalled traffic");
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: modular_multiply_64.f
rtl/mm64_pkg.sv
rtl/mm64_if.sv
rtl/mm64_red_cell.sv
rtl/mm64_mul_cell.sv
rtl/modular_multiply_64.sv
sim/tb_top.sv
